FILE: design/pltl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pltl_pkg: shared constants and types for the page table translator
// Field widths, age limits, parameter defaults and the control state type.
// ----------------------------------------------------------------------------
package pltl_pkg;

    localparam int ADDR_W  = 12;
    localparam int PHYS_W  = 10;
    localparam int FAULT_W = 32;
    localparam int AGE_W   = 3;

    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    localparam int PAGE_BYTES_DEF  = 128;
    localparam int PAGE_COUNT_DEF  = 32;
    localparam int FRAME_COUNT_DEF = 8;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } t_state;

endpackage
`default_nettype wire

FILE: design/page_table_lru_translate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_lru_translate: demand-paging address translation with LRU
// Flow: an accepted input beat is resolved in the resolve state, and its
// result beat is registered on the output; one item is in flight at a time,
// with the page table read on accept and written back in the resolve cycle.
// Reset: synchronous, active low; clears all page valid bits, frame ages,
// owner valid bits and the fault count at once, and marks frames above 0 free.
// ----------------------------------------------------------------------------
module page_table_lru_translate #(
    parameter int PAGE_BYTES  = pltl_pkg::PAGE_BYTES_DEF,
    parameter int PAGE_COUNT  = pltl_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = pltl_pkg::FRAME_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [pltl_pkg::ADDR_W-1:0]  i_logical_address,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [pltl_pkg::PHYS_W-1:0]       o_physical_address,
    output logic                              o_page_fault,
    output logic [pltl_pkg::FAULT_W-1:0]      o_fault_total
);

    localparam int OFFS_W = $clog2(PAGE_BYTES);
    localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FR_W   = $clog2(FRAME_COUNT);
    localparam int EXT_W  = FR_W + OFFS_W + pltl_pkg::PHYS_W;

    pltl_pkg::t_state r_state, n_state;

    logic [FR_W-1:0]             r_frame_mem [PAGE_COUNT];
    logic [FR_W-1:0]             r_rd_frame;
    logic [PAGE_COUNT-1:0]       r_page_valid;
    logic [FRAME_COUNT-1:0]      r_free;
    logic [FRAME_COUNT-1:0]      r_owner_vld;
    logic [PG_W-1:0]             r_owner [FRAME_COUNT];
    logic [pltl_pkg::AGE_W-1:0]  r_age [FRAME_COUNT];
    logic [pltl_pkg::FAULT_W-1:0] r_fault_cnt;

    logic [PG_W-1:0]             r_page;
    logic [OFFS_W-1:0]           r_offset;
    logic [FR_W-1:0]             r_pick;

    logic                        r_out_valid;
    logic [pltl_pkg::PHYS_W-1:0] r_phys;
    logic                        r_fault;

    logic                        in_fire;
    logic                        resolve;
    logic [pltl_pkg::ADDR_W-1:0] shifted;
    logic [PG_W-1:0]             in_page;
    logic                        hit;
    logic [FR_W-1:0]             frame;
    logic [FR_W-1:0]             n_pick;
    logic [EXT_W-1:0]            phys_ext;

    assign in_fire  = i_in_valid && o_in_ready;
    assign shifted  = i_logical_address >> OFFS_W;
    assign in_page  = shifted[PG_W-1:0];
    assign hit      = r_page_valid[r_page];
    assign frame    = hit ? r_rd_frame : r_pick;
    assign phys_ext = {{pltl_pkg::PHYS_W{1'b0}}, frame, r_offset};

    always_comb begin
        n_state = r_state;
        case (r_state)
            pltl_pkg::ST_IDLE:    if (in_fire) n_state = pltl_pkg::ST_RESOLVE;
            pltl_pkg::ST_RESOLVE: n_state = pltl_pkg::ST_IDLE;
            default:              n_state = pltl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        resolve    = 1'b0;
        case (r_state)
            pltl_pkg::ST_IDLE:    o_in_ready = !r_out_valid || i_out_ready;
            pltl_pkg::ST_RESOLVE: resolve = 1'b1;
            default:              o_in_ready = 1'b0;
        endcase
    end

    // victim: lowest free frame above 0, else oldest occupied frame
    always_comb begin
        logic                       found;
        logic [FR_W-1:0]            free_idx;
        logic [FR_W-1:0]            best;
        logic [pltl_pkg::AGE_W-1:0] best_age;
        found    = 1'b0;
        free_idx = FR_W'(1);
        best     = FR_W'(1);
        best_age = r_age[1];
        for (int i = FRAME_COUNT - 1; i >= 1; i--) begin
            if (r_free[i]) begin
                found    = 1'b1;
                free_idx = FR_W'(i);
            end
        end
        for (int i = 2; i < FRAME_COUNT; i++) begin
            if (r_age[i] > best_age) begin
                best     = FR_W'(i);
                best_age = r_age[i];
            end
        end
        n_pick = found ? free_idx : best;
    end

    always_ff @(posedge i_clk) begin
        r_pick <= n_pick;
        if (in_fire) begin
            r_rd_frame <= r_frame_mem[in_page];
            r_page     <= in_page;
            r_offset   <= i_logical_address[OFFS_W-1:0];
        end
        if (resolve && !hit) begin
            r_frame_mem[r_page] <= r_pick;
            r_owner[r_pick]     <= r_page;
        end
        if (resolve) begin
            r_phys  <= phys_ext[pltl_pkg::PHYS_W-1:0];
            r_fault <= !hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pltl_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_page_valid <= '0;
            r_owner_vld  <= '0;
            r_fault_cnt  <= '0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_free[i] <= (i != 0);
                r_age[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (resolve) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (resolve) begin
                if (!hit) begin
                    if (r_owner_vld[r_pick]) begin
                        r_page_valid[r_owner[r_pick]] <= 1'b0;
                    end
                    r_page_valid[r_page] <= 1'b1;
                    r_owner_vld[r_pick]  <= 1'b1;
                    r_free[r_pick]       <= 1'b0;
                    if (r_fault_cnt != '1) begin
                        r_fault_cnt <= r_fault_cnt + 1'b1;
                    end
                end
                for (int i = 1; i < FRAME_COUNT; i++) begin
                    if (FR_W'(i) != frame && !r_free[i] && r_age[i] < pltl_pkg::AGE_MAX) begin
                        r_age[i] <= r_age[i] + 1'b1;
                    end
                end
                r_age[frame] <= '0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_phys;
    assign o_page_fault       = r_fault;
    assign o_fault_total      = r_fault_cnt;

endmodule
`default_nettype wire

FILE: design/pltl_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pltl_check: port-level checks for the page table translator
// Watches handshakes and the running fault count on result beats.
// ----------------------------------------------------------------------------
module pltl_check (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [pltl_pkg::PHYS_W-1:0]  o_physical_address,
    input wire logic                         o_page_fault,
    input wire logic [pltl_pkg::FAULT_W-1:0] o_fault_total
);

    logic                         in_fire;
    logic                         out_fire;
    logic [pltl_pkg::FAULT_W-1:0] r_last_total;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_total <= '0;
        end else if (out_fire) begin
            r_last_total <= o_fault_total;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_physical_address)
            && $stable(o_page_fault) && $stable(o_fault_total))
        else $error("result beat dropped or changed while stalled");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> ##1 o_out_valid)
        else $error("result beat missing two cycles after input beat");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && o_page_fault && r_last_total != '1 |->
            o_fault_total == r_last_total + 1'b1)
        else $error("fault count did not advance on a faulting beat");

    a_hit_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !o_page_fault |-> o_fault_total == r_last_total)
        else $error("fault count moved on a hit beat");

endmodule

bind page_table_lru_translate pltl_check u_pltl_check (.*);
`default_nettype wire
